/* rtl/core/sha_pkg.sv */
package sha_pkg;

  // item held in the queue between front and back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } back_state_t;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction

endpackage

/* rtl/core/sha_byte_if.sv */
interface sha_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       message_end;
  modport source (output valid, data_byte, byte_valid, message_end, input ready);
  modport sink (input valid, data_byte, byte_valid, message_end, output ready);
endinterface

/* rtl/core/sha_digest_if.sv */
interface sha_digest_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* rtl/core/sha_front.sv */
module sha_front (
  input  logic              clk,
  input  logic              rst,
  sha_byte_if.sink          in_ch,
  output logic              q_valid,
  input  logic              q_ready,
  output sha_pkg::item_t    q_item
);
  // two-entry queue; idle words are dropped here
  sha_pkg::item_t slot [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       push;
  logic       pop;
  logic       useful;

  assign useful    = in_ch.byte_valid | in_ch.message_end;
  assign in_ch.ready = (count != 2'd2);
  assign push      = in_ch.valid & in_ch.ready & useful;
  assign q_valid   = (count != 2'd0);
  assign pop       = q_valid & q_ready;
  assign q_item    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{data_byte: in_ch.data_byte, byte_valid: in_ch.byte_valid,
                        message_end: in_ch.message_end};
    end
  end
endmodule

/* rtl/core/sha_back.sv */
module sha_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  sha_pkg::item_t    q_item,
  sha_digest_if.source      out_ch
);
  sha_pkg::back_state_t state, state_next;

  logic [31:0] hash_words [8];
  logic [31:0] wv [8];
  logic [31:0] win [16];
  logic [6:0]  fill_count;
  logic [63:0] bit_length;
  logic [5:0]  round;
  logic        final_pending;
  logic        pad_done;
  logic        marker_written;
  logic [1:0]  emit_idx;
  logic [63:0] out_word;

  // round datapath
  logic [31:0] wt, w_new, s0, s1, big0, big1, ch, maj, t1, t2;
  logic [3:0]  wpos;

  assign wpos = round[3:0];
  assign s1 = sha_pkg::rotr(win[4'(wpos - 4'd2)], 17) ^ sha_pkg::rotr(win[4'(wpos - 4'd2)], 19)
            ^ (win[4'(wpos - 4'd2)] >> 10);
  assign s0 = sha_pkg::rotr(win[4'(wpos - 4'd15)], 7) ^ sha_pkg::rotr(win[4'(wpos - 4'd15)], 18)
            ^ (win[4'(wpos - 4'd15)] >> 3);
  assign w_new = s1 + win[4'(wpos - 4'd7)] + s0 + win[wpos];
  assign wt   = (round < 6'd16) ? win[wpos] : w_new;
  assign big1 = sha_pkg::rotr(wv[4], 6) ^ sha_pkg::rotr(wv[4], 11) ^ sha_pkg::rotr(wv[4], 25);
  assign ch   = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
  assign t1   = wv[7] + big1 + ch + sha_pkg::ROUND_K[round] + wt;
  assign big0 = sha_pkg::rotr(wv[0], 2) ^ sha_pkg::rotr(wv[0], 13) ^ sha_pkg::rotr(wv[0], 22);
  assign maj  = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
  assign t2   = big0 + maj;

  // byte lane into the window, big-endian inside each 32-bit entry
  logic       wr_en;
  logic [7:0] wr_byte;
  logic [5:0] wr_pos;

  assign out_word = {hash_words[{emit_idx, 1'b0}], hash_words[{emit_idx, 1'b1}]};
  assign out_ch.valid       = (state == sha_pkg::ST_EMIT);
  assign out_ch.digest_word = out_word;
  assign out_ch.word_index  = emit_idx;
  assign out_ch.last_word   = (emit_idx == 2'd3);

  // next state and controls
  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    wr_en      = 1'b0;
    wr_byte    = q_item.data_byte;
    wr_pos     = fill_count[5:0];
    unique case (state)
      sha_pkg::ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          wr_en = q_item.byte_valid;
          if (q_item.byte_valid && fill_count == 7'd63) begin
            state_next = sha_pkg::ST_LOAD;
          end else if (q_item.message_end) begin
            state_next = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_LOAD:  state_next = sha_pkg::ST_ROUND;
      sha_pkg::ST_ROUND: if (round == 6'd63) state_next = sha_pkg::ST_ADD;
      sha_pkg::ST_ADD: begin
        if (final_pending) begin
          state_next = pad_done ? sha_pkg::ST_EMIT : sha_pkg::ST_PAD;
        end else begin
          state_next = sha_pkg::ST_IDLE;
        end
      end
      sha_pkg::ST_PAD: begin
        // one padding byte a cycle
        wr_en = 1'b1;
        if (!marker_written) begin
          wr_byte = sha_pkg::PAD_MARK;
        end else if (fill_count >= 7'd56) begin
          wr_byte = pad_done ? bit_length[8'(7'd63 - fill_count) * 8 +: 8] : 8'h00;
        end else begin
          wr_byte = 8'h00;
        end
        if (fill_count == 7'd63) state_next = sha_pkg::ST_LOAD;
      end
      sha_pkg::ST_EMIT: if (out_ch.ready && emit_idx == 2'd3) state_next = sha_pkg::ST_IDLE;
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= sha_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // pad flags: marker goes in on the first pad cycle, length once byte 55 is behind
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= 7'd0;
      bit_length     <= 64'd0;
      final_pending  <= 1'b0;
      pad_done       <= 1'b0;
      marker_written <= 1'b0;
      emit_idx       <= 2'd0;
      round          <= 6'd0;
      for (int i = 0; i < 8; i++) hash_words[i] <= sha_pkg::INIT_HASH[i];
    end else begin
      unique case (state)
        sha_pkg::ST_IDLE: begin
          round <= 6'd0;
          if (q_valid) begin
            if (q_item.byte_valid) begin
              bit_length <= bit_length + 64'd8;
              fill_count <= (fill_count == 7'd63) ? 7'd0 : fill_count + 7'd1;
            end
            if (q_item.message_end) begin
              final_pending  <= 1'b1;
              marker_written <= 1'b0;
              pad_done       <= 1'b0;
            end
          end
        end
        sha_pkg::ST_LOAD: round <= 6'd0;
        sha_pkg::ST_ROUND: round <= round + 6'd1;
        sha_pkg::ST_ADD: begin
          for (int i = 0; i < 8; i++) hash_words[i] <= hash_words[i] + wv[i];
          round <= 6'd0;
        end
        sha_pkg::ST_PAD: begin
          marker_written <= 1'b1;
          // length goes in only if the marker fit before byte 56
          if (fill_count == 7'd55 && marker_written) pad_done <= 1'b1;
          if (!marker_written && fill_count <= 7'd55) pad_done <= (fill_count == 7'd55);
          fill_count <= (fill_count == 7'd63) ? 7'd0 : fill_count + 7'd1;
        end
        sha_pkg::ST_EMIT: begin
          if (out_ch.ready) begin
            emit_idx <= emit_idx + 2'd1;
            if (emit_idx == 2'd3) begin
              final_pending <= 1'b0;
              bit_length    <= 64'd0;
              fill_count    <= 7'd0;
              for (int i = 0; i < 8; i++) hash_words[i] <= sha_pkg::INIT_HASH[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // message window and working variables
  always_ff @(posedge clk) begin
    if (wr_en) begin
      win[wr_pos[5:2]][8'(3 - wr_pos[1:0]) * 8 +: 8] <= wr_byte;
    end
    if (state == sha_pkg::ST_LOAD) begin
      for (int i = 0; i < 8; i++) wv[i] <= hash_words[i];
    end
    if (state == sha_pkg::ST_ROUND) begin
      if (round >= 6'd16) win[wpos] <= w_new;
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end
endmodule

/* rtl/core/sha256_stream_hasher.sv */
// Streaming SHA-256: send one message byte per word on in_ch, with message_end on the
// last word (byte_valid 0 with message_end alone ends an empty message). A two-word
// queue decouples the input from the compression engine. Bytes are taken while the
// engine is idle; every 64th byte starts a compression (load, 64 rounds, hash add),
// during which further input waits in the queue. The end of a message adds padding
// bytes up to the block end plus one or two compressions, then the digest leaves on
// out_ch as four 64-bit big-endian words, index 0 first.
module sha256_stream_hasher (
  input  logic          clk,
  input  logic          rst,
  sha_byte_if.sink      in_ch,
  sha_digest_if.source  out_ch
);
  logic           q_valid;
  logic           q_ready;
  sha_pkg::item_t q_item;

  sha_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  sha_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_ch(out_ch)
  );
endmodule

/* rtl/core/sha_checker.sv */
module sha_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] digest_word,
  input logic [1:0]  word_index,
  input logic        last_word
);
  // last flag only on the final word
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 2'd3)))
    else $error("last_word mismatch");

  // words come in order
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=> out_valid && word_index == $past(word_index) + 2'd1)
    else $error("digest word order broken");

  // stalled word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word))
    else $error("digest word changed under stall");
endmodule

bind sha256_stream_hasher sha_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .digest_word(out_ch.digest_word), .word_index(out_ch.word_index),
  .last_word(out_ch.last_word)
);

/* sim/sha256_stream_hasher_test.sv */
`timescale 1ns / 100ps

module sha256_stream_hasher_test;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } digest_rec_t;

  logic clk;
  logic rst;

  sha_byte_if   in_ch();
  sha_digest_if out_ch();

  sha256_stream_hasher dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  logic [31:0] hash_state [8];
  logic [7:0]  block_buf [64];
  int          fill_level;
  logic [63:0] msg_bits;

  digest_rec_t digest_queue [$];
  int errors;
  int bytes_sent;
  int items_sent;
  int words_seen;
  int messages_sent;
  longint cycles;
  bit hold_off;
  bit no_gaps;

  function automatic logic [31:0] ror32(logic [31:0] v, int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // one 64-round compression over block_buf
  task automatic compress_buf();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, g, h, wt, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        s1 = ror32(w[(t-2)%16], 17) ^ ror32(w[(t-2)%16], 19) ^ (w[(t-2)%16] >> 10);
        s0 = ror32(w[(t-15)%16], 7) ^ ror32(w[(t-15)%16], 18) ^ (w[(t-15)%16] >> 3);
        wt = s1 + w[(t-7)%16] + s0 + w[t%16];
        w[t%16] = wt;
      end
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + sha_pkg::ROUND_K[t] + wt;
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::INIT_HASH[i];
    fill_level = 0;
    msg_bits = '0;
  endtask

  // absorb one word and queue the digest on message end
  task automatic predict_digest(logic [7:0] data, logic bv, logic me);
    digest_rec_t r;
    if (bv) begin
      block_buf[fill_level] = data;
      msg_bits += 64'd8;
      fill_level++;
      if (fill_level == 64) begin
        compress_buf();
        fill_level = 0;
      end
    end
    if (!me) return;
    block_buf[fill_level] = sha_pkg::PAD_MARK;
    fill_level++;
    if (fill_level > 56) begin
      while (fill_level < 64) begin
        block_buf[fill_level] = 8'h00;
        fill_level++;
      end
      compress_buf();
      fill_level = 0;
    end
    while (fill_level < 56) begin
      block_buf[fill_level] = 8'h00;
      fill_level++;
    end
    for (int k = 0; k < 8; k++) block_buf[56+k] = msg_bits[63-8*k -: 8];
    compress_buf();
    for (int k = 0; k < 4; k++) begin
      r.digest_word = {hash_state[2*k], hash_state[2*k+1]};
      r.word_index = k[1:0];
      r.last_word = (k == 3);
      digest_queue.insert(digest_queue.size(), r);
    end
    restart_hash();
  endtask

  // clock and cycle limit
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int gap_len();
    if (no_gaps) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // send one word and predict on acceptance
  task automatic send_word(logic [7:0] data, logic bv, logic me);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.byte_valid <= bv;
    in_ch.message_end <= me;
    do @(posedge clk); while (!in_ch.ready);
    predict_digest(data, bv, me);
    items_sent++;
    if (bv) bytes_sent++;
    if (me) messages_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(int len, int pattern);
    logic [7:0] v;
    for (int i = 0; i < len; i++) begin
      case (pattern)
        0: v = 8'h00;
        1: v = 8'hff;
        default: v = 8'($urandom_range(0, 255));
      endcase
      if (i == len - 1 && $urandom_range(0, 1)) begin
        send_word(v, 1'b1, 1'b1);
        return;
      end
      send_word(v, 1'b1, 1'b0);
    end
    send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      if (no_gaps) out_ch.ready <= 1'b1;
      else if ($urandom_range(0, 29) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(10, 50)) @(negedge clk);
      end else out_ch.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    digest_rec_t x;
    if (!rst && out_ch.valid && out_ch.ready) begin
      words_seen++;
      if (digest_queue.size() == 0) begin
        $error("digest word with nothing expected: %h", out_ch.digest_word);
        errors++;
      end else begin
        x = digest_queue.pop_front();
        if (out_ch.digest_word !== x.digest_word) begin
          $error("digest_word expected %h actual %h", x.digest_word, out_ch.digest_word);
          errors++;
        end
        if (out_ch.word_index !== x.word_index) begin
          $error("word_index expected %0d actual %0d", x.word_index, out_ch.word_index);
          errors++;
        end
        if (out_ch.last_word !== x.last_word) begin
          $error("last_word expected %0b actual %0b", x.last_word, out_ch.last_word);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h5a, 1'b0, 1'b0);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hff, 1'b0, 1'b1);
    send_message(1, 0);
    send_message(3, 1);
  endtask

  // lengths around the padding boundaries
  task automatic test_block_edges();
    int lens [4] = '{55, 56, 63, 64};
    foreach (lens[i]) send_message(lens[i], i % 3);
  endtask

  task automatic test_random();
    int len;
    while (items_sent < 320) begin
      if ($urandom_range(0, 9) == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 72) : $urandom_range(0, 12);
      send_message(len, 2);
    end
  endtask

  // receiver holds off while sender keeps pushing
  task automatic test_backpressure();
    hold_off = 1;
    no_gaps = 1;
    repeat (6) send_message($urandom_range(0, 3), 2);
    no_gaps = 0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    errors = 0; bytes_sent = 0; items_sent = 0; words_seen = 0; messages_sent = 0;
    cycles = 0; hold_off = 0; no_gaps = 0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.byte_valid = 1'b0;
    in_ch.message_end = 1'b0;
    restart_hash();
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_block_edges();
    test_backpressure();
    test_random();
    drain();
    $display("covered %0d messages, %0d words in, %0d bytes, %0d digest words checked",
             messages_sent, items_sent, bytes_sent, words_seen);
    $display("including empty, boundary-length and backpressured messages");
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
rtl/core/sha_pkg.sv
rtl/core/sha_byte_if.sv
rtl/core/sha_digest_if.sv
rtl/core/sha_front.sv
rtl/core/sha_back.sv
rtl/core/sha256_stream_hasher.sv
rtl/core/sha_checker.sv
sim/sha256_stream_hasher_test.sv
